FILE: rtl/core/frc_pkg.sv
// ----------------------------------------------------------------------------
// Frequency rank cracker package
// Shared types, command codes and helpers for the frequency rank cracker.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int COUNT_BITS  = 20;
    localparam int LETTERS     = 26;
    localparam int LETTER_BITS = 5;

    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [LETTER_BITS-1:0] t_letter;

    // Command codes carried on the input channel.
    typedef enum logic [2:0] {
        CMD_CLEAR     = 3'd0,
        CMD_SAMPLE    = 3'd1,
        CMD_CIPHER    = 3'd2,
        CMD_DERIVE    = 3'd3,
        CMD_TRANSLATE = 3'd4
    } t_cmd;

    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_BYTE = 1'b1;

    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LZ = 8'h7a;
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UZ = 8'h5a;

    // Input item payload.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] byte_in;
    } t_in_item;

    // Result item payload.
    typedef struct packed {
        logic       kind;
        t_letter    cipher_letter;
        t_letter    plain_letter;
        logic [7:0] byte_out;
        logic       last;
    } t_out_item;

    // Control from the sequencer to every histogram cell.
    typedef struct packed {
        logic    clear;
        logic    bump_s;
        logic    bump_c;
        t_letter bump_idx;
        logic    load;      // capture own counts into the rank tokens
        logic    shift;     // pass tokens one cell down the chain
        logic    compare;   // compare own count against the passing token
    } t_cell_ctrl;

    // A token circulating through the chain: one letter with its count.
    typedef struct packed {
        t_count  cnt;
        t_letter idx;
    } t_token;

    function automatic logic is_letter(input logic [7:0] b);
        is_letter = ((b >= CHAR_LA) && (b <= CHAR_LZ)) || ((b >= CHAR_UA) && (b <= CHAR_UZ));
    endfunction

    function automatic t_letter letter_of(input logic [7:0] b);
        logic [7:0] d;
        d = (b >= CHAR_LA) ? (b - CHAR_LA) : (b - CHAR_UA);
        letter_of = d[LETTER_BITS-1:0];
    endfunction

    // True when token a ranks ahead of letter b with count cb.
    function automatic logic ranks_ahead(input t_token a, input t_count cb, input t_letter b);
        ranks_ahead = (a.cnt > cb) || ((a.cnt == cb) && (a.idx > b));
    endfunction

endpackage

FILE: rtl/core/frc_stream_if.sv
// ----------------------------------------------------------------------------
// Frequency rank cracker stream interface
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface frc_stream_if #(type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/frc_cell.sv
// ----------------------------------------------------------------------------
// Frequency rank cracker cell
// Holds one letter's sample and cipher bins. During derive, tokens of every
// letter pass through the chain and each cell counts how many rank ahead.
// ----------------------------------------------------------------------------
module frc_cell
    import frc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_letter    i_idx,
    input  t_cell_ctrl i_ctrl,
    input  t_token     i_tok_s,
    input  t_token     i_tok_c,
    output t_token     o_tok_s,
    output t_token     o_tok_c,
    output t_letter    o_pos_s,
    output t_letter    o_pos_c
);

    t_count  r_cnt_s, r_cnt_c;
    t_token  r_tok_s, r_tok_c;
    t_letter r_pos_s, r_pos_c;
    logic    w_hit;

    assign w_hit = i_ctrl.bump_idx == i_idx;

    // Histogram bins with saturation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_cnt_s <= '0;
            r_cnt_c <= '0;
        end else begin
            if (i_ctrl.bump_s && w_hit && (r_cnt_s != '1)) r_cnt_s <= r_cnt_s + 1'b1;
            if (i_ctrl.bump_c && w_hit && (r_cnt_c != '1)) r_cnt_c <= r_cnt_c + 1'b1;
        end
    end

    // Circulating tokens and rank counters.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_tok_s <= '{cnt: r_cnt_s, idx: i_idx};
            r_tok_c <= '{cnt: r_cnt_c, idx: i_idx};
            r_pos_s <= '0;
            r_pos_c <= '0;
        end else begin
            if (i_ctrl.compare) begin
                if (ranks_ahead(r_tok_s, r_cnt_s, i_idx)) r_pos_s <= r_pos_s + 1'b1;
                if (ranks_ahead(r_tok_c, r_cnt_c, i_idx)) r_pos_c <= r_pos_c + 1'b1;
            end
            if (i_ctrl.shift) begin
                r_tok_s <= i_tok_s;
                r_tok_c <= i_tok_c;
            end
        end
    end

    assign o_tok_s = r_tok_s;
    assign o_tok_c = r_tok_c;
    assign o_pos_s = r_pos_s;
    assign o_pos_c = r_pos_c;

endmodule

FILE: rtl/core/frequency_rank_substitution_cracker.sv
// Count and clear items act at acceptance; translate registers its result at
// acceptance, valid in the next cycle, at one item per cycle while the receiver
// keeps up. Derive rotates the tokens through the cell chain, then a scan state
// fills the rank tables, then pairs follow at one pair per cycle while the
// receiver keeps up; input is held off until the last pair is registered.
// Reset (synchronous, active low) zeroes histograms and key table.
// ----------------------------------------------------------------------------
// Frequency rank substitution cracker
// Letter histograms, rank-matched key derivation and byte translation.
// ----------------------------------------------------------------------------
module frequency_rank_substitution_cracker
    import frc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    frc_stream_if.sink   s_in,
    frc_stream_if.source m_out
);

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_ROT  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    t_letter    r_step;
    t_cell_ctrl w_ctrl;
    t_token     w_tok_s [LETTERS];
    t_token     w_tok_c [LETTERS];
    t_letter    w_pos_s [LETTERS];
    t_letter    w_pos_c [LETTERS];
    t_letter    r_srank [LETTERS];
    t_letter    r_crank [LETTERS];
    t_letter    r_key   [LETTERS];
    logic       r_ovalid;
    t_out_item  r_odata;
    logic       w_acc, w_take, w_free;
    t_in_item   w_in;
    t_letter    w_c, w_p, w_l, w_k;

    assign w_in   = s_in.data;
    assign w_take = m_out.ready && r_ovalid;
    assign w_free = !r_ovalid || m_out.ready;
    assign s_in.ready = (r_state == ST_RUN) && w_free;
    assign w_acc  = s_in.valid && s_in.ready;

    // Cell control derived from the accepted item and the sequencer.
    always_comb begin
        w_ctrl          = '0;
        w_ctrl.clear    = w_acc && (w_in.cmd == CMD_CLEAR);
        w_ctrl.bump_s   = w_acc && (w_in.cmd == CMD_SAMPLE) && is_letter(w_in.byte_in);
        w_ctrl.bump_c   = w_acc && (w_in.cmd == CMD_CIPHER) && is_letter(w_in.byte_in);
        w_ctrl.bump_idx = letter_of(w_in.byte_in);
        w_ctrl.load     = w_acc && (w_in.cmd == CMD_DERIVE);
        w_ctrl.shift    = r_state == ST_ROT;
        w_ctrl.compare  = r_state == ST_ROT;
    end

    // Row of cells; tokens ring from the last cell back to the first.
    for (genvar g = 0; g < LETTERS; g++) begin : g_cell
        localparam int PREV = (g == 0) ? LETTERS - 1 : g - 1;
        frc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (LETTER_BITS'(g)),
            .i_ctrl  (w_ctrl),
            .i_tok_s (w_tok_s[PREV]),
            .i_tok_c (w_tok_c[PREV]),
            .o_tok_s (w_tok_s[g]),
            .o_tok_c (w_tok_c[g]),
            .o_pos_s (w_pos_s[g]),
            .o_pos_c (w_pos_c[g])
        );
    end

    // Sequencer state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN:  if (w_ctrl.load) n_state = ST_ROT;
            ST_ROT:  if (r_step == t_letter'(LETTERS - 1)) n_state = ST_SCAN;
            ST_SCAN: n_state = ST_EMIT;
            ST_EMIT: if (w_free && r_step == t_letter'(LETTERS - 1)) n_state = ST_RUN;
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ROT || r_state == ST_SCAN) begin
                r_step <= (r_state == ST_SCAN) ? '0 : r_step + 1'b1;
            end else if (r_state == ST_EMIT && w_free) begin
                r_step <= (r_step == t_letter'(LETTERS - 1)) ? '0 : r_step + 1'b1;
            end
        end
    end

    // Scatter each cell's rank into the rank tables.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN) begin
            for (int i = 0; i < LETTERS; i++) begin
                r_srank[w_pos_s[i]] <= t_letter'(i);
                r_crank[w_pos_c[i]] <= t_letter'(i);
            end
        end
    end

    assign w_c = r_crank[r_step];
    assign w_p = r_srank[r_step];
    assign w_l = letter_of(w_in.byte_in);
    assign w_k = r_key[w_l];

    // Key table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LETTERS; i++) r_key[i] <= '0;
        end else if (r_state == ST_EMIT && w_free) begin
            r_key[w_c] <= w_p;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_EMIT && w_free) begin
            r_ovalid <= 1'b1;
            r_odata  <= '{kind: KIND_PAIR, cipher_letter: w_c, plain_letter: w_p,
                          byte_out: 8'h00, last: r_step == t_letter'(LETTERS - 1)};
        end else if (w_acc && w_in.cmd == CMD_TRANSLATE) begin
            r_ovalid <= 1'b1;
            r_odata  <= '{kind: KIND_BYTE, cipher_letter: '0, plain_letter: '0,
                          byte_out: !is_letter(w_in.byte_in) ? w_in.byte_in :
                                    ((w_in.byte_in >= CHAR_LA) ? CHAR_LA + 8'(w_k)
                                                               : CHAR_UA + 8'(w_k)),
                          last: 1'b1};
        end else if (w_take) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_odata;

    // No item is taken while a derive is in progress.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !s_in.ready) else $error("input taken during derive");
    // A derive walks exactly the rotation length before scanning.
    a_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> $past(r_step) == t_letter'(LETTERS - 1))
        else $error("rotation length wrong");
    // A pair marked last returns the sequencer to idle.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_free && r_step == t_letter'(LETTERS - 1)) |=>
        (r_state == ST_RUN && m_out.data.last)) else $error("derive did not finish");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency rank substitution cracker testbench
// Drives count, clear, derive and translate items through the input channel.
// Every result is compared against a local letter-frequency key predictor.
// The run starts with a directed table, then moves to random text sessions
// under several idling and stall settings.
// ----------------------------------------------------------------------------
module testbench;
    import frc_pkg::*;

    // Command codes that the block ignores.
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID = 3'd6;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    frc_stream_if #(.T(t_in_item))  in_if();
    frc_stream_if #(.T(t_out_item)) out_if();

    frequency_rank_substitution_cracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_if.sink),
        .m_out   (out_if.source)
    );

    // Predictor state.
    t_count     sample_hist [LETTERS];
    t_count     cipher_hist [LETTERS];
    t_letter    key_map     [LETTERS];
    t_out_item  expected_q  [$];

    int error_count;
    int items_sent;
    int results_seen;
    int derive_count;

    // Sender-side context for the item on the channel.
    logic       row_typed;
    logic [7:0] row_byte;

    // Idling controls.
    int src_idle_pct;
    int sink_stall_pct;
    int sink_hold_left;

    // Directed table row.
    typedef struct {
        logic [2:0] cmd;
        logic [7:0] b;
        logic       typed;
        logic [7:0] exp_byte;
    } t_row;

    t_row rows [$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected.", expected_q.size());
        $display("** frequency_rank_substitution_cracker: FAILED **");
        $finish;
    end

    function automatic bit letter_byte(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic t_letter letter_index(input logic [7:0] b);
        logic [7:0] d;
        d = (b >= 8'h61) ? b - 8'h61 : b - 8'h41;
        return d[4:0];
    endfunction

    // Rank a histogram: descending count, ties put the higher letter first.
    function automatic void rank_letters(input t_count h [LETTERS],
                                         output t_letter order [LETTERS]);
        int pos;
        for (int l = 0; l < LETTERS; l++) begin
            pos = 0;
            for (int m = 0; m < LETTERS; m++) begin
                if (m != l && (h[m] > h[l] || (h[m] == h[l] && m > l)))
                    pos++;
            end
            order[pos] = t_letter'(l);
        end
    endfunction

    // Update the predictor for one accepted item and queue its results.
    task automatic predict_item(input logic [2:0] cmd, input logic [7:0] b,
                                input logic typed, input logic [7:0] typed_byte);
        t_letter   s_order [LETTERS];
        t_letter   c_order [LETTERS];
        t_out_item r;
        t_letter   k;
        case (cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < LETTERS; i++) begin
                    sample_hist[i] = '0;
                    cipher_hist[i] = '0;
                end
            end
            CMD_SAMPLE: begin
                if (letter_byte(b) && sample_hist[letter_index(b)] != '1)
                    sample_hist[letter_index(b)]++;
            end
            CMD_CIPHER: begin
                if (letter_byte(b) && cipher_hist[letter_index(b)] != '1)
                    cipher_hist[letter_index(b)]++;
            end
            CMD_DERIVE: begin
                rank_letters(sample_hist, s_order);
                rank_letters(cipher_hist, c_order);
                for (int i = 0; i < LETTERS; i++) begin
                    key_map[c_order[i]] = s_order[i];
                    r = '0;
                    r.kind = KIND_PAIR;
                    r.cipher_letter = c_order[i];
                    r.plain_letter = s_order[i];
                    r.last = (i == LETTERS - 1);
                    expected_q.push_back(r);
                end
                derive_count++;
            end
            CMD_TRANSLATE: begin
                r = '0;
                r.kind = KIND_BYTE;
                r.last = 1'b1;
                r.byte_out = b;
                if (letter_byte(b)) begin
                    k = key_map[letter_index(b)];
                    r.byte_out = (b >= 8'h61) ? 8'h61 + k : 8'h41 + k;
                end
                if (typed)
                    r.byte_out = typed_byte;
                expected_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("Mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Input acceptance and result checking at the rising edge.
    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item g;
        if (i_rst_n && in_if.valid && in_if.ready)
            predict_item(in_if.data.cmd, in_if.data.byte_in, row_typed, row_byte);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            g = out_if.data;
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", g));
            end else begin
                e = expected_q.pop_front();
                if (g.kind !== e.kind)
                    report_mismatch($sformatf("kind %b, want %b", g.kind, e.kind));
                if (g.cipher_letter !== e.cipher_letter)
                    report_mismatch($sformatf("cipher_letter %0d, want %0d",
                                              g.cipher_letter, e.cipher_letter));
                if (g.plain_letter !== e.plain_letter)
                    report_mismatch($sformatf("plain_letter %0d, want %0d",
                                              g.plain_letter, e.plain_letter));
                if (g.byte_out !== e.byte_out)
                    report_mismatch($sformatf("byte_out %h, want %h",
                                              g.byte_out, e.byte_out));
                if (g.last !== e.last)
                    report_mismatch($sformatf("last %b, want %b", g.last, e.last));
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request.
    always @(negedge i_clk) begin
        if (sink_hold_left > 0) begin
            sink_hold_left <= sink_hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one item and hold it until it is accepted; valid stays high
    // afterwards so the next item can follow without a gap.
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] b,
                             input logic typed, input logic [7:0] typed_byte);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= '{cmd: cmd, byte_in: b};
        row_typed <= typed;
        row_byte <= typed_byte;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_text_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return 8'h61 + 8'($urandom_range(25));
        if (roll < 80)
            return 8'h41 + 8'($urandom_range(25));
        return 8'($urandom);
    endfunction

    // Skewed letters so rankings differ from the tie order.
    function automatic logic [7:0] skewed_byte();
        logic [7:0] b;
        b = 8'h61 + 8'($urandom_range($urandom_range(25)));
        if ($urandom_range(1))
            b = b - 8'h20;
        return ($urandom_range(9) == 0) ? 8'($urandom) : b;
    endfunction

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // One text session: optional clear, count both texts, optional derive, translate.
    task automatic run_session(input bit hold_output);
        int n;
        if ($urandom_range(3) != 0)
            send_item(CMD_CLEAR, 8'($urandom), 1'b0, 8'h00);
        n = $urandom_range(30, 6);
        for (int i = 0; i < n; i++)
            send_item(CMD_SAMPLE, skewed_byte(), 1'b0, 8'h00);
        n = $urandom_range(30, 6);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                send_item(3'($urandom_range(7, 5)), 8'($urandom), 1'b0, 8'h00);
            else
                send_item(CMD_CIPHER, skewed_byte(), 1'b0, 8'h00);
        end
        if (hold_output)
            sink_hold_left = 400;
        if ($urandom_range(7) != 0)
            send_item(CMD_DERIVE, 8'($urandom), 1'b0, 8'h00);
        n = $urandom_range(20, 5);
        for (int i = 0; i < n; i++)
            send_item(CMD_TRANSLATE, random_text_byte(), 1'b0, 8'h00);
    endtask

    initial begin
        int pct_src [4];
        int pct_sink [4];
        int start;
        pct_src  = '{0, 64, 0, 30};
        pct_sink = '{0, 0, 64, 30};
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        derive_count = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        sink_hold_left = 0;
        row_typed = 1'b0;
        row_byte = 8'h00;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        for (int i = 0; i < LETTERS; i++) begin
            sample_hist[i] = '0;
            cipher_hist[i] = '0;
            key_map[i] = '0;
        end

        // Directed rows; after reset every letter translates to a, keeping its case.
        rows = '{
            '{CMD_TRANSLATE, 8'h61, 1'b1, 8'h61},
            '{CMD_TRANSLATE, 8'h7a, 1'b1, 8'h61},
            '{CMD_TRANSLATE, 8'h41, 1'b1, 8'h41},
            '{CMD_TRANSLATE, 8'h5a, 1'b1, 8'h41},
            '{CMD_TRANSLATE, 8'h00, 1'b1, 8'h00},
            '{CMD_TRANSLATE, 8'hff, 1'b1, 8'hff},
            '{CMD_TRANSLATE, 8'h40, 1'b1, 8'h40},
            '{CMD_TRANSLATE, 8'h7b, 1'b1, 8'h7b},
            '{CMD_DERIVE,    8'h00, 1'b0, 8'h00},
            '{CMD_SAMPLE,    8'h41, 1'b0, 8'h00},
            '{CMD_SAMPLE,    8'h7a, 1'b0, 8'h00},
            '{CMD_SAMPLE,    8'h40, 1'b0, 8'h00},
            '{CMD_SAMPLE,    8'h7b, 1'b0, 8'h00},
            '{CMD_CIPHER,    8'h51, 1'b0, 8'h00},
            '{CMD_CIPHER,    8'h71, 1'b0, 8'h00},
            '{CMD_CIPHER,    8'h5b, 1'b0, 8'h00},
            '{CMD_CIPHER,    8'h60, 1'b0, 8'h00},
            '{CMD_RSVD_LO,   8'h61, 1'b0, 8'h00},
            '{CMD_RSVD_MID,  8'h80, 1'b0, 8'h00},
            '{CMD_RSVD_HI,   8'hff, 1'b0, 8'h00},
            '{CMD_DERIVE,    8'hff, 1'b0, 8'h00},
            '{CMD_TRANSLATE, 8'h71, 1'b0, 8'h00},
            '{CMD_TRANSLATE, 8'h51, 1'b0, 8'h00},
            '{CMD_CLEAR,     8'h55, 1'b0, 8'h00},
            '{CMD_DERIVE,    8'haa, 1'b0, 8'h00}
        };

        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].b, rows[i].typed, rows[i].exp_byte);
        wait_drained();

        // Random sessions under each idling setting.
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = pct_src[ph];
            sink_stall_pct = pct_sink[ph];
            start = items_sent;
            while (items_sent - start < 45)
                run_session(ph == 0 && items_sent - start == 0);
            // The sender pauses until every result is back.
            wait_drained();
        end

        repeat (100) @(negedge i_clk);
        $display("Sent %0d items with %0d derives; checked %0d results.",
                 items_sent, derive_count, results_seen);
        $display("Idling phases: none, sender, receiver, both; one long receiver hold.");
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("** frequency_rank_substitution_cracker: PASSED **");
        end else begin
            $display("** frequency_rank_substitution_cracker: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/frc_pkg.sv
rtl/core/frc_stream_if.sv
rtl/core/frc_cell.sv
rtl/core/frequency_rank_substitution_cracker.sv
test/testbench.sv
